// ----- sv/ldrl_pkg.sv -----
// ----------------------------------------------------------------------------
// ldrl_pkg
// Shared constants, types and helpers for the longest distinct run block.
// ----------------------------------------------------------------------------
package ldrl_pkg;

	localparam int ALPHABET = 256;
	localparam int SYM_W    = $clog2(ALPHABET);
	localparam int CHAR_W   = 8;
	localparam int LEN_W    = 16;
	localparam logic [LEN_W-1:0] MAX_LEN = 16'd65535;

	typedef logic [SYM_W-1:0] sym_t;
	typedef logic [LEN_W-1:0] len_t;

	// table write request from the update stage
	typedef struct packed {
		logic en;   // write next_after_seen entry and set its seen mark
		logic clr;  // end of string: drop all seen marks
		sym_t addr;
		len_t data;
	} tbl_wr_t;

	// result leaving the update stage
	typedef struct packed {
		len_t best;
		logic ovf;
	} ldrl_res_t;

	// bytes beyond the alphabet fold onto its last symbol
	function automatic sym_t clamp_sym(input logic [CHAR_W-1:0] c);
		sym_t s;
		if (int'(c) >= ALPHABET) begin
			s = sym_t'(ALPHABET - 1);
		end else begin
			s = c[SYM_W-1:0];
		end
		return s;
	endfunction

endpackage

// ----- sv/ldrl_table.sv -----
// ----------------------------------------------------------------------------
// ldrl_table
// Last-seen table: synchronous RAM for positions plus flop seen marks.
// ----------------------------------------------------------------------------
module ldrl_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  ldrl_pkg::sym_t   rd_addr,
	output ldrl_pkg::len_t   rd_data,   // registered, valid in the cycle after rd_en
	input  ldrl_pkg::sym_t   seen_addr,
	output logic             seen,
	input  ldrl_pkg::tbl_wr_t wr
);

	ldrl_pkg::len_t mem [ldrl_pkg::ALPHABET];
	logic           seen_q [ldrl_pkg::ALPHABET];
	ldrl_pkg::len_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// clear wins over a write in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ldrl_pkg::ALPHABET; i++) seen_q[i] <= 1'b0;
		end else if (wr.clr) begin
			for (int i = 0; i < ldrl_pkg::ALPHABET; i++) seen_q[i] <= 1'b0;
		end else if (wr.en) begin
			seen_q[wr.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;
	assign seen    = seen_q[seen_addr];

endmodule

// ----- sv/ldrl_update.sv -----
// ----------------------------------------------------------------------------
// ldrl_update
// Window, position and best-length registers with the per-byte update.
// ----------------------------------------------------------------------------
module ldrl_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               last,
	input  ldrl_pkg::sym_t     sym,
	input  logic               seen,
	input  ldrl_pkg::len_t     nas,     // next_after_seen, already forwarded
	output ldrl_pkg::tbl_wr_t  wr,
	output ldrl_pkg::ldrl_res_t res
);

	ldrl_pkg::len_t window_start_q, position_q, best_q;
	logic           ovf_q;

	logic           full, hit;
	ldrl_pkg::len_t run_len;
	ldrl_pkg::len_t window_start_d, position_d, best_d;
	logic           ovf_d;

	always_comb begin
		full    = (position_q >= ldrl_pkg::MAX_LEN);
		hit     = seen && (nas >= window_start_q);
		run_len = position_q - window_start_q + ldrl_pkg::len_t'(1);
		window_start_d = window_start_q;
		position_d     = position_q;
		best_d         = best_q;
		ovf_d          = ovf_q;
		if (full) begin
			ovf_d = 1'b1;
		end else begin
			if (hit) begin
				window_start_d = nas;
			end else if (run_len > best_q) begin
				best_d = run_len;
			end
			position_d = position_q + ldrl_pkg::len_t'(1);
		end
		wr.en   = fire && !full;
		wr.clr  = fire && last;
		wr.addr = sym;
		wr.data = position_q + ldrl_pkg::len_t'(1);
		res.best = best_d;
		res.ovf  = ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			position_q     <= '0;
			best_q         <= '0;
			ovf_q          <= 1'b0;
		end else if (fire) begin
			if (last) begin
				window_start_q <= '0;
				position_q     <= '0;
				best_q         <= '0;
				ovf_q          <= 1'b0;
			end else begin
				window_start_q <= window_start_d;
				position_q     <= position_d;
				best_q         <= best_d;
				ovf_q          <= ovf_d;
			end
		end
	end

endmodule

// ----- sv/longest_distinct_run_length.sv -----
// ----------------------------------------------------------------------------
// longest_distinct_run_length
// Longest run of bytes without a repeat, one string per tlast-marked frame.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one byte per word on s_tdata, s_tlast on the final byte.
//   Master side gives one word per string: the longest distinct run length on
//   m_tdata and the too-long flag on m_tuser.
//   Throughput: one byte per cycle unless a final byte holds in the update
//   stage. An accepted byte issues the table read; in the update stage it
//   is resolved against the window and written back, and a final byte's
//   result word goes to the output register. One table RAM read/write pair
//   per byte sets that rate; a read racing the prior write uses forwarding.
//   Reset clears the counters and all seen marks at once (flops), so the
//   block is ready as soon as reset ends; no clearing pass.
//   Stall: while the result word waits, non-final bytes keep flowing; only a
//   final byte holds in the update stage until the output register frees.
// ----------------------------------------------------------------------------
module longest_distinct_run_length (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] char_in
	input  logic        s_tlast,    // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] longest_length
	output logic [0:0]  m_tuser     // [0] too_long
);

	// update stage
	logic           valid_s1;
	logic           last_s1;
	ldrl_pkg::sym_t sym_s1;
	logic           fwd_hit_s1;
	ldrl_pkg::len_t fwd_data_s1;

	// output register
	logic           m_tvalid_q;
	ldrl_pkg::len_t len_q;
	logic           ovf_q;

	logic                accept, out_free, s1_fire, seen;
	ldrl_pkg::sym_t      sym_in;
	ldrl_pkg::len_t      rd_data, nas;
	ldrl_pkg::tbl_wr_t   wr;
	ldrl_pkg::ldrl_res_t res;

	assign sym_in   = ldrl_pkg::clamp_sym(s_tdata);
	assign out_free = !m_tvalid_q || m_tready;
	// only a final byte needs the output slot
	assign s1_fire  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_fire;
	assign accept   = s_tvalid && s_tready;
	// the RAM read of this byte saw the old entry if the byte ahead wrote it
	assign nas      = fwd_hit_s1 ? fwd_data_s1 : rd_data;

	ldrl_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr   (sym_in),
		.rd_data   (rd_data),
		.seen_addr (sym_s1),
		.seen      (seen),
		.wr        (wr)
	);

	ldrl_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_fire),
		.last   (last_s1),
		.sym    (sym_s1),
		.seen   (seen),
		.nas    (nas),
		.wr     (wr),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1     <= s_tlast;
			sym_s1      <= sym_in;
			fwd_hit_s1  <= wr.en && (wr.addr == sym_in);
			fwd_data_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			len_q <= res.best;
			ovf_q <= res.ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = len_q;
	assign m_tuser  = ovf_q;

`ifndef SYNTH
	// a final byte waiting on a full output slot blocks new bytes
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && m_tvalid_q && !m_tready |-> !s_tready)
		else $error("final byte stalled but input still ready");

	// a final byte leaving the update stage always lands in the output register
	a_last_lands: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && last_s1 |=> m_tvalid_q)
		else $error("final byte fired without a result word");

	// a new result word comes only from a final byte
	a_word_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(s1_fire && last_s1))
		else $error("result word without a final byte");
`endif

endmodule
